>>> design/ids_pkg.sv
package ids_pkg;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned NT_W     = 11;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 3'd0,
    MODE_POP   = 3'd1,
    MODE_READ  = 3'd2,
    MODE_WRITE = 3'd3,
    MODE_SETTOP = 3'd4,
    MODE_CLEAR = 3'd5,
    MODE_REV   = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the operands of an accepted transaction
    logic exec;       // carry out the latched operation
    logic rev_rd;     // read the mirrored pair at lo and hi-1
    logic rev_wr_lo;  // write the upper entry of the pair to lo
    logic rev_wr_hi;  // write the lower entry of the pair to hi-1, step inward
    logic rsp_rd;     // emit a result that carries the read data
    logic rsp_plain;  // emit a result with zero data
  } ids_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_op;      // latched operation is a pop or read that needs memory data
    logic rev_op;     // latched operation is a reverse
    logic rev_more;   // at least one more pair remains to be swapped
  } ids_stat_t;

endpackage

>>> design/indexed_int_stack_core.sv
// A stack of 1024 signed 32-bit entries with push, pop, indexed read and write, set top,
// clear and in-place reverse. A transaction is taken when start_i is high and busy_o is
// low; its single result appears on the result ports for exactly one cycle with done_o
// high and cannot be held off, so the receiver must take it in that cycle. Push, write,
// set top, clear and errors give their result after the execute state; pop and read also
// pass through a read state for the registered memory read. Reverse reads each
// mirrored pair on the two read ports at once and writes it back one entry at a time
// through the single write port. A new transaction may be started
// in the same cycle in which the previous result is shown. Reading an entry that was
// never written returns an undefined value.
module indexed_int_stack_core import ids_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic [IDX_W-1:0]    index_i,
  input  logic [NT_W-1:0]     new_top_i,
  output logic                done_o,
  output logic [DATA_W-1:0]   data_o,
  output logic [COUNT_W-1:0]  count_o,
  output logic                empty_res_o,
  output logic [STATUS_W-1:0] status_o
);

  ids_cmd_t  cmd;
  ids_stat_t stat;

  ids_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  ids_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .index_i    (index_i),
    .new_top_i  (new_top_i),
    .done_o     (done_o),
    .data_o     (data_o),
    .count_o    (count_o),
    .empty_res_o(empty_res_o),
    .status_o   (status_o)
  );

  // An accepted transaction keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepting a transaction");

  // A result is only shown once the block has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

  // Every transaction passes through the execute state after acceptance, so results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // Overflow is reported only when the stack is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_OVER)) |-> (count_o == COUNT_W'(DEPTH)))
    else $error("overflow reported on a stack that is not full");

  // The empty flag matches a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (empty_res_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

endmodule

>>> design/ids_ctrl.sv
module ids_ctrl import ids_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  ids_stat_t stat_i,
  output ids_cmd_t  cmd_o,
  output logic      busy_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_READ   = 6'b000100,
    S_REV_RD = 6'b001000,
    S_REV_LO = 6'b010000,
    S_REV_HI = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.rd_op) begin
          state_d = S_READ;
        end else if (stat_i.rev_op) begin
          state_d = S_REV_RD;
        end else begin
          cmd_o.rsp_plain = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rsp_rd = 1'b1;
        state_d      = S_IDLE;
      end
      S_REV_RD: begin
        if (stat_i.rev_more) begin
          cmd_o.rev_rd = 1'b1;
          state_d      = S_REV_LO;
        end else begin
          cmd_o.rsp_plain = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_REV_LO: begin
        cmd_o.rev_wr_lo = 1'b1;
        state_d         = S_REV_HI;
      end
      S_REV_HI: begin
        cmd_o.rev_wr_hi = 1'b1;
        state_d         = S_REV_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> design/ids_dpath.sv
module ids_dpath import ids_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ids_cmd_t            cmd_i,
  output ids_stat_t           stat_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic [IDX_W-1:0]    index_i,
  input  logic [NT_W-1:0]     new_top_i,
  output logic                done_o,
  output logic [DATA_W-1:0]   data_o,
  output logic [COUNT_W-1:0]  count_o,
  output logic                empty_res_o,
  output logic [STATUS_W-1:0] status_o
);

  logic [DATA_W-1:0]   mem_q [DEPTH];
  logic [DATA_W-1:0]   rd_a_q, rd_b_q;

  logic [MODE_W-1:0]   mode_q;
  logic [DATA_W-1:0]   value_q;
  logic [IDX_W-1:0]    index_q;
  logic [NT_W-1:0]     new_top_q;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [ADDR_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]    hi_q, hi_d;

  logic                done_q;
  logic [DATA_W-1:0]   data_q;
  logic [STATUS_W-1:0] status_q, status_d;

  logic                full, idx_bad, nt_bad;
  logic signed [31:0]  nt_x, nt_p1;
  logic [CNT_W-1:0]    count_m1, hi_m1, lo_p1;

  logic                we;
  logic [ADDR_W-1:0]   wr_addr, rd_a_addr, rd_b_addr;
  logic [DATA_W-1:0]   wr_data;

  assign full     = (32'(count_q) >= 32'(DEPTH));
  assign idx_bad  = (32'(index_q) >= 32'(DEPTH));
  assign nt_x     = 32'($signed(new_top_q));
  assign nt_p1    = nt_x + 32'sd1;
  assign nt_bad   = (nt_x < -32'sd1) || (nt_x >= $signed(32'(DEPTH)));
  assign count_m1 = count_q - CNT_W'(1);
  assign hi_m1    = hi_q - CNT_W'(1);
  assign lo_p1    = CNT_W'(lo_q) + CNT_W'(1);

  assign stat_o.rd_op    = ((mode_q == MODE_POP) && (count_q != '0))
                        || ((mode_q == MODE_READ) && !idx_bad);
  assign stat_o.rev_op   = (mode_q == MODE_REV);
  assign stat_o.rev_more = (lo_p1 < hi_q);

  // Operation decode under exec, plus the address and data steering of the reverse steps.
  always_comb begin
    count_d   = count_q;
    status_d  = ST_OK;
    we        = 1'b0;
    wr_addr   = count_q[ADDR_W-1:0];
    wr_data   = value_q;
    rd_a_addr = count_m1[ADDR_W-1:0];
    rd_b_addr = hi_m1[ADDR_W-1:0];
    lo_d      = lo_q;
    hi_d      = hi_q;
    if (cmd_i.exec) begin
      lo_d = '0;
      hi_d = count_q;
      case (mode_q)
        MODE_PUSH: begin
          if (full) begin
            status_d = ST_OVER;
          end else begin
            we      = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        MODE_POP: begin
          if (count_q == '0) begin
            status_d = ST_UNDER;
          end else begin
            count_d = count_m1;
          end
        end
        MODE_READ: begin
          rd_a_addr = ADDR_W'(index_q);
          if (idx_bad) begin
            status_d = ST_RANGE;
          end
        end
        MODE_WRITE: begin
          wr_addr = ADDR_W'(index_q);
          if (idx_bad) begin
            status_d = ST_RANGE;
          end else begin
            we = 1'b1;
          end
        end
        MODE_SETTOP: begin
          if (nt_bad) begin
            status_d = ST_RANGE;
          end else begin
            count_d = nt_p1[CNT_W-1:0];
          end
        end
        MODE_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.rev_rd) begin
      rd_a_addr = lo_q;
    end
    if (cmd_i.rev_wr_lo) begin
      we      = 1'b1;
      wr_addr = lo_q;
      wr_data = rd_b_q;
    end
    if (cmd_i.rev_wr_hi) begin
      we      = 1'b1;
      wr_addr = hi_m1[ADDR_W-1:0];
      wr_data = rd_a_q;
      lo_d    = lo_p1[ADDR_W-1:0];
      hi_d    = hi_m1;
    end
  end

  // The read registers hold their data until both entries of a pair are written back.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.exec || cmd_i.rev_rd) begin
      rd_a_q <= mem_q[rd_a_addr];
    end
    if (cmd_i.rev_rd) begin
      rd_b_q <= mem_q[rd_b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q    <= mode_i;
      value_q   <= value_i;
      index_q   <= index_i;
      new_top_q <= new_top_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
    end
    if (cmd_i.rsp_rd) begin
      data_q <= rd_a_q;
    end else if (cmd_i.rsp_plain) begin
      data_q <= '0;
    end
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.rsp_rd | cmd_i.rsp_plain;
    end
  end

  assign done_o      = done_q;
  assign data_o      = data_q;
  assign count_o     = COUNT_W'(count_q);
  assign empty_res_o = (count_q == '0);
  assign status_o    = status_q;

endmodule

>>> tb/indexed_int_stack_core_tb.sv
module indexed_int_stack_core_tb;
  import ids_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int NUM_RANDOM = 1700;
  localparam int CALM_TAIL = 300;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic [NT_W-1:0]   new_top;
  } stack_cmd_t;

  typedef struct {
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    status_e            status;
  } stack_result_t;

  // Mirrors the stack contents and tells which entries hold a written value, so
  // that stimulus never reads an entry whose contents are undefined.
  class stack_scoreboard;
    logic [DATA_W-1:0] mem [DEPTH];
    bit                written [DEPTH];
    int                live;
    stack_result_t     pending [$];
    int                errors;

    function void note_input(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                             logic [IDX_W-1:0] index, logic [NT_W-1:0] new_top);
      stack_result_t res;
      int nt;
      int lo;
      int hi;
      logic [DATA_W-1:0] tmp_d;
      bit tmp_w;
      res.data = '0;
      res.status = ST_OK;
      nt = int'($signed(new_top));
      case (mode)
        MODE_PUSH: begin
          if (live >= DEPTH) begin
            res.status = ST_OVER;
          end else begin
            mem[live] = value;
            written[live] = 1'b1;
            live++;
          end
        end
        MODE_POP: begin
          if (live == 0) begin
            res.status = ST_UNDER;
          end else begin
            live--;
            res.data = mem[live];
          end
        end
        MODE_READ: begin
          if (int'(index) >= DEPTH) res.status = ST_RANGE;
          else res.data = mem[index];
        end
        MODE_WRITE: begin
          if (int'(index) >= DEPTH) begin
            res.status = ST_RANGE;
          end else begin
            mem[index] = value;
            written[index] = 1'b1;
          end
        end
        MODE_SETTOP: begin
          if (nt < -1 || nt >= int'(DEPTH)) res.status = ST_RANGE;
          else live = nt + 1;
        end
        MODE_CLEAR: begin
          live = 0;
        end
        MODE_REV: begin
          lo = 0;
          hi = live;
          while (lo + 1 < hi) begin
            hi--;
            tmp_d = mem[lo];
            mem[lo] = mem[hi];
            mem[hi] = tmp_d;
            tmp_w = written[lo];
            written[lo] = written[hi];
            written[hi] = tmp_w;
            lo++;
          end
        end
        default: begin
        end
      endcase
      res.count = live[COUNT_W-1:0];
      res.empty_res = (live == 0);
      pending.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] data, logic [COUNT_W-1:0] count,
                               logic empty_res, logic [STATUS_W-1:0] status);
      stack_result_t exp_res;
      if (pending.size() == 0) begin
        $error("Result with no transaction outstanding: data %h count %0d", data, count);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (data !== exp_res.data) begin
        $error("data: expected %h, actual %h", exp_res.data, data);
        errors++;
      end
      if (count !== exp_res.count) begin
        $error("count: expected %0d, actual %0d", exp_res.count, count);
        errors++;
      end
      if (empty_res !== exp_res.empty_res) begin
        $error("empty_res: expected %b, actual %b", exp_res.empty_res, empty_res);
        errors++;
      end
      if (status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [MODE_W-1:0]   mode_i;
  logic [DATA_W-1:0]   value_i;
  logic [IDX_W-1:0]    index_i;
  logic [NT_W-1:0]     new_top_i;
  logic                done_o;
  logic [DATA_W-1:0]   data_o;
  logic [COUNT_W-1:0]  count_o;
  logic                empty_res_o;
  logic [STATUS_W-1:0] status_o;

  stack_scoreboard sb = new();

  indexed_int_stack_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .new_top_i   (new_top_i),
    .done_o      (done_o),
    .data_o      (data_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The result of the previous transaction is checked before a transaction taken
  // at the same edge is noted; the queue keeps them in order either way.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) sb.check_result(data_o, count_o, empty_res_o, status_o);
      if (start_i === 1'b1 && busy_o === 1'b0) sb.note_input(mode_i, value_i, index_i, new_top_i);
    end
  end

  function automatic stack_cmd_t next_random_cmd();
    stack_cmd_t c;
    int cnt;
    int pick;
    int nt;
    int hi_idx;
    cnt = sb.live;
    c.value = $urandom();
    pick = $urandom_range(0, 9);
    if (pick == 0) c.value = 32'h7FFF_FFFF;
    else if (pick == 1) c.value = 32'h8000_0000;
    c.index = IDX_W'($urandom());
    c.new_top = NT_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 26) c.mode = MODE_PUSH;
    else if (pick < 46) c.mode = MODE_POP;
    else if (pick < 60) c.mode = MODE_READ;
    else if (pick < 74) c.mode = MODE_WRITE;
    else if (pick < 82) c.mode = MODE_SETTOP;
    else if (pick < 85) c.mode = MODE_CLEAR;
    else if (pick < 96) c.mode = MODE_REV;
    else c.mode = MODE_UNUSED;

    // Long reversals are slow, so most of them on a deep stack become a set top.
    if (c.mode == MODE_REV && cnt > 64 && $urandom_range(0, 9) != 0) c.mode = MODE_SETTOP;

    if (c.mode == MODE_WRITE && cnt > 0 && $urandom_range(0, 4) < 3) begin
      hi_idx = (cnt + 3 > DEPTH - 1) ? DEPTH - 1 : cnt + 3;
      c.index = IDX_W'($urandom_range(0, hi_idx));
    end
    if (c.mode == MODE_READ && cnt > 0 && $urandom_range(0, 3) != 0) begin
      c.index = IDX_W'($urandom_range(0, cnt - 1));
    end
    // An entry with undefined contents is written instead of read.
    if (c.mode == MODE_READ && !sb.written[c.index]) c.mode = MODE_WRITE;
    if (c.mode == MODE_POP && cnt > 0 && !sb.written[cnt - 1]) begin
      c.mode = MODE_WRITE;
      c.index = IDX_W'(cnt - 1);
    end

    if (c.mode == MODE_SETTOP) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) nt = $urandom_range(0, 41) - 1;
      else if (pick < 16) nt = $urandom_range(1000, 1023);
      else nt = -$urandom_range(2, 1024);
      c.new_top = nt[NT_W-1:0];
    end
    return c;
  endfunction

  task automatic drive_cmd(input stack_cmd_t c);
    start_i   <= 1'b1;
    mode_i    <= c.mode;
    value_i   <= c.value;
    index_i   <= c.index;
    new_top_i <= c.new_top;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic issue(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                       input logic [IDX_W-1:0] index, input logic [NT_W-1:0] new_top);
    stack_cmd_t c;
    c.mode = mode;
    c.value = value;
    c.index = index;
    c.new_top = new_top;
    @(negedge clk_i);
    drive_cmd(c);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  initial begin
    stack_cmd_t c;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    mode_i    = '0;
    value_i   = '0;
    index_i   = '0;
    new_top_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    issue(MODE_POP, '0, '0, '0);
    issue(MODE_PUSH, 32'h7FFF_FFFF, '0, '0);
    issue(MODE_PUSH, 32'h8000_0000, '0, '0);
    issue(MODE_PUSH, 32'h0000_0000, '0, '0);
    issue(MODE_PUSH, 32'hFFFF_FFFF, '0, '0);
    issue(MODE_READ, '0, 10'd0, '0);
    issue(MODE_READ, '0, 10'd3, '0);
    issue(MODE_WRITE, 32'h5A5A_5A5A, 10'd1023, '0);
    issue(MODE_READ, '0, 10'd1023, '0);
    issue(MODE_POP, '0, '0, '0);
    issue(MODE_SETTOP, '0, '0, 11'(-2));
    issue(MODE_SETTOP, '0, '0, 11'(-1024));
    // Raising the top to the last entry fills the stack, so the next push overflows.
    issue(MODE_SETTOP, '0, '0, 11'd1023);
    issue(MODE_PUSH, 32'hDEAD_BEEF, '0, '0);
    issue(MODE_POP, '0, '0, '0);
    issue(MODE_PUSH, 32'h1234_5678, '0, '0);
    issue(MODE_REV, '0, '0, '0);
    issue(MODE_READ, '0, 10'd0, '0);
    issue(MODE_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 11'h7FF);
    issue(MODE_SETTOP, '0, '0, 11'(-1));
    issue(MODE_REV, '0, '0, '0);
    issue(MODE_PUSH, 32'h0F0F_0F0F, '0, '0);
    issue(MODE_CLEAR, '0, '0, '0);
    issue(MODE_PUSH, 32'hAAAA_5555, '0, '0);
    issue(MODE_REV, '0, '0, '0);
    issue(MODE_PUSH, 32'h5555_AAAA, '0, '0);
    issue(MODE_REV, '0, '0, '0);
    issue(MODE_POP, '0, '0, '0);
    issue(MODE_POP, '0, '0, '0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i < NUM_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0) idle_gap();
      @(negedge clk_i);
      c = next_random_cmd();
      drive_cmd(c);
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Worst case is every transaction being a full-depth reverse.
  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
